// ----- hdl/vtpd_pkg.sv -----
// Shared types, constants and helpers for the vertex transform core.
package vtpd_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned VecSize   = 4;
  localparam int unsigned WordW     = 32;
  localparam int unsigned CoefCnt   = VecSize * VecSize;
  localparam int unsigned IdxW      = $clog2(CoefCnt);
  localparam int unsigned ProdW     = 2 * WordW;
  localparam int unsigned SumW      = ProdW + 2;
  // numerator (p << FracBits) width
  localparam int unsigned NumW      = WordW + FracBits;
  // quotient magnitude width: one bit per shift-subtract cell
  localparam int unsigned QuoW      = NumW;
  localparam int unsigned DivCells  = QuoW;
  localparam int unsigned CompW     = 2;  // bits of component index

  localparam logic signed [WordW-1:0] S32Max = {1'b0, {(WordW-1){1'b1}}};
  localparam logic signed [WordW-1:0] S32Min = {1'b1, {(WordW-1){1'b0}}};
  localparam logic [WordW-1:0] OneFix = WordW'(1) << FracBits;

  typedef enum logic {
    ReqLoad      = 1'b0,
    ReqTransform = 1'b1
  } req_type_e;

  typedef logic signed [WordW-1:0] word_t;
  typedef word_t vec_t [VecSize];

  // One divider lane's payload as it walks down the cell row
  typedef struct packed {
    logic [NumW-1:0]  rem;    // partial remainder (magnitude)
    logic [NumW-1:0]  num;    // remaining numerator bits, msb first
    logic [QuoW-1:0]  quo;    // quotient bits so far
    logic [WordW-1:0] den;    // |w|
    logic             neg;    // sign of the final quotient
  } div_lane_t;

  // Side data of one vertex traveling with the divider lanes
  typedef struct packed {
    logic valid;
    logic wzero;
    logic sat;
  } div_tag_t;

  // Clamp a wide signed value to the word range, report clamping
  function automatic word_t clamp_word(input logic signed [SumW-1:0] v,
                                       output logic sat);
    word_t r;
    sat = 1'b0;
    r   = v[WordW-1:0];
    if (v > SumW'(S32Max)) begin
      sat = 1'b1;
      r   = S32Max;
    end else if (v < $signed({{(SumW-WordW){1'b1}}, S32Min})) begin
      sat = 1'b1;
      r   = S32Min;
    end
    return r;
  endfunction

endpackage

// ----- hdl/vtpd_div_cell.sv -----
// One restoring-division step for all four lanes of a vertex.
module vtpd_div_cell
  import vtpd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  div_tag_t  tag_i,
  input  div_lane_t lane_i [VecSize],
  output div_tag_t  tag_o,
  output div_lane_t lane_o [VecSize]
);

  div_lane_t lane_d [VecSize];
  div_lane_t lane_q [VecSize];
  div_tag_t  tag_q;

  // shift in the next numerator bit, subtract the divisor if it fits
  always_comb begin
    for (int l = 0; l < VecSize; l++) begin
      logic [NumW:0] trial;
      trial = {lane_i[l].rem, lane_i[l].num[NumW-1]};
      lane_d[l]     = lane_i[l];
      lane_d[l].num = {lane_i[l].num[NumW-2:0], 1'b0};
      if (trial >= {{(NumW+1-WordW){1'b0}}, lane_i[l].den}) begin
        lane_d[l].rem = NumW'(trial - {{(NumW+1-WordW){1'b0}}, lane_i[l].den});
        lane_d[l].quo = {lane_i[l].quo[QuoW-2:0], 1'b1};
      end else begin
        lane_d[l].rem = trial[NumW-1:0];
        lane_d[l].quo = {lane_i[l].quo[QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign tag_o  = tag_q;
  assign lane_o = lane_q;

endmodule

// ----- hdl/vtpd_xform.sv -----
// Matrix store and two-stage row-vector by matrix product.
module vtpd_xform
  import vtpd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            load_i,
  input  logic [IdxW-1:0] idx_i,
  input  word_t           coef_i,
  input  logic            vtx_i,
  input  vec_t            v_i,
  output div_tag_t        tag_o,
  output vec_t            p_o
);

  word_t coef_q [CoefCnt];
  // stage 1: products
  logic signed [ProdW-1:0] prod_q [CoefCnt];
  logic                    s1_valid_q;
  // stage 2: floored, clamped sums
  vec_t                    p_q;
  div_tag_t                tag_q;
  vec_t                    p_d;
  logic                    sat_d;

  // coefficient store, reset to identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < VecSize; r++) begin
        for (int c = 0; c < VecSize; c++) begin
          coef_q[r*VecSize+c] <= (r == c) ? word_t'(OneFix) : '0;
        end
      end
    end else if (load_i) begin
      coef_q[idx_i] <= coef_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < VecSize; k++) begin
        for (int j = 0; j < VecSize; j++) begin
          prod_q[k*VecSize+j] <= ProdW'(v_i[k]) * ProdW'(coef_q[k*VecSize+j]);
        end
      end
    end
  end

  // exact sum floored to FracBits equals floor of summed exact products
  always_comb begin
    logic sat_any;
    logic sat_j;
    logic signed [SumW-1:0] acc;
    sat_any = 1'b0;
    for (int j = 0; j < VecSize; j++) begin
      acc = '0;
      for (int k = 0; k < VecSize; k++) begin
        acc = acc + SumW'(prod_q[k*VecSize+j]);
      end
      acc = acc >>> FracBits;
      p_d[j] = clamp_word(acc, sat_j);
      sat_any = sat_any | sat_j;
    end
    sat_d = sat_any;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      tag_q      <= '0;
    end else if (en_i) begin
      s1_valid_q <= vtx_i;
      tag_q.valid <= s1_valid_q;
      tag_q.sat   <= sat_d;
      tag_q.wzero <= (p_d[VecSize-1] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign tag_o = tag_q;
  assign p_o   = p_q;

endmodule

// ----- hdl/vertex_transform_perspective_divide_core.sv -----
// Top level: vertex transform with perspective divide.
//
// Usage
//   One input channel (in_valid_i / in_stall_o) carries requests: a load
//   request (req_type 0) writes one matrix coefficient and makes no result;
//   a transform request (req_type 1) makes one result on the output channel
//   (out_valid_o / out_stall_i).
//   Throughput: one request per cycle while the output is not stalled. A
//   transform passes the matrix product stages, the divider cell row (one
//   quotient bit per cell) and the sign fix and clamping register.
//   The whole pipe advances as one; when the receiver stalls with a result
//   in the output register, the pipe freezes and in_stall_o is raised.
//   A load request writes the matrix at once; a transform accepted in a
//   later cycle sees it.
//   Reset clears the pipe and sets the matrix to identity.
module vertex_transform_perspective_divide_core
  import vtpd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            req_type_i,
  input  logic [IdxW-1:0] coef_index_i,
  input  word_t           coef_value_i,
  input  word_t           in_x_i,
  input  word_t           in_y_i,
  input  word_t           in_z_i,
  input  word_t           in_w_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output word_t           out_x_o,
  output word_t           out_y_o,
  output word_t           out_z_o,
  output word_t           out_w_o,
  output logic            w_was_zero_o,
  output logic            saturated_o
);

  logic     adv;
  logic     in_acc;
  vec_t     v_in;
  vec_t     p;
  div_tag_t xtag;

  div_tag_t  head_tag;
  div_lane_t head_lane [VecSize];
  div_tag_t  ctag  [DivCells+1];
  div_lane_t clane [DivCells+1][VecSize];

  logic  out_valid_q;
  word_t out_q [VecSize];
  logic  wzero_q;
  logic  sat_q;
  word_t out_d [VecSize];
  logic  sat_d;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;
  assign v_in[0] = in_x_i;
  assign v_in[1] = in_y_i;
  assign v_in[2] = in_z_i;
  assign v_in[3] = in_w_i;

  vtpd_xform u_xform (
    .clk_i,
    .rst_ni,
    .en_i   (adv),
    .load_i (in_acc && req_type_i == ReqLoad),
    .idx_i  (coef_index_i),
    .coef_i (coef_value_i),
    .vtx_i  (in_acc && req_type_i == ReqTransform),
    .v_i    (v_in),
    .tag_o  (xtag),
    .p_o    (p)
  );

  // load magnitudes into the head of the divider row
  always_comb begin
    logic [WordW-1:0] wmag;
    wmag = p[VecSize-1][WordW-1] ? WordW'(-p[VecSize-1]) : p[VecSize-1];
    head_tag = xtag;
    for (int l = 0; l < VecSize; l++) begin
      head_lane[l].rem = '0;
      head_lane[l].num = {(p[l][WordW-1] ? WordW'(-p[l]) : p[l]), {FracBits{1'b0}}};
      head_lane[l].quo = '0;
      head_lane[l].den = xtag.wzero ? WordW'(1) : wmag;
      head_lane[l].neg = p[l][WordW-1] ^ p[VecSize-1][WordW-1];
    end
  end

  assign ctag[0]  = head_tag;
  assign clane[0] = head_lane;

  for (genvar c = 0; c < DivCells; c++) begin : g_cell
    vtpd_div_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i   (adv),
      .tag_i  (ctag[c]),
      .lane_i (clane[c]),
      .tag_o  (ctag[c+1]),
      .lane_o (clane[c+1])
    );
  end

  // sign fix and clamp; w==0 divides by one, so the upper quotient bits
  // give the product magnitude back
  always_comb begin
    logic s;
    logic signed [SumW-1:0] q;
    sat_d = ctag[DivCells].sat;
    for (int l = 0; l < VecSize; l++) begin
      if (ctag[DivCells].wzero) begin
        q = SumW'(clane[DivCells][l].quo[QuoW-1:FracBits]);
      end else begin
        q = SumW'(clane[DivCells][l].quo);
      end
      if (clane[DivCells][l].neg) begin
        q = -q;
      end
      out_d[l] = clamp_word(q, s);
      sat_d = sat_d | (s & ~ctag[DivCells].wzero);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctag[DivCells].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q   <= out_d;
      wzero_q <= ctag[DivCells].wzero;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_q[0];
  assign out_y_o      = out_q[1];
  assign out_z_o      = out_q[2];
  assign out_w_o      = out_q[3];
  assign w_was_zero_o = wzero_q;
  assign saturated_o  = sat_q;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) && $stable(out_w_o))
    else $error("stalled result changed");
  // input is stalled exactly when the output register is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall mismatch");
  // a divided result has w of one unless clamped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !w_was_zero_o && !saturated_o |-> out_w_o == word_t'(OneFix))
    else $error("divided w is not one");

endmodule

// ----- sim/testbench.sv -----
// Testbench for the vertex transform core: directed table, then random requests.
module testbench
  import vtpd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] x, y, z, w;
    logic        wz, sat;
  } vertex_res_t;

  typedef struct {
    req_type_e   kind;
    logic [3:0]  idx;
    logic [31:0] coef;
    logic [31:0] vx, vy, vz, vw;
    logic        typed;     // expected result typed in below
    vertex_res_t res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = 1'b0;
  logic [3:0]  coef_index_i = '0;
  word_t       coef_value_i = '0;
  word_t       in_x_i = '0, in_y_i = '0, in_z_i = '0, in_w_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  word_t       out_x_o, out_y_o, out_z_o, out_w_o;
  logic        w_was_zero_o, saturated_o;

  vertex_transform_perspective_divide_core dut (.*);

  localparam logic [31:0] One = 32'h0001_0000;

  // predictor state
  logic [31:0] mat_shadow [16];
  vertex_res_t pending_res [$];
  int          errors = 0;
  bit          calm = 1'b0;     // no idling in the final part
  bit          long_hold = 1'b0;

  // clamp to signed 32 bits
  function automatic logic signed [63:0] sat32(input logic signed [63:0] v,
                                               inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // row vector times matrix, floor to Q16.16, then divide by w
  function automatic vertex_res_t transform_vertex(input logic [31:0] vx, vy, vz, vw);
    logic signed [63:0] v [4];
    logic signed [63:0] p [4];
    logic signed [95:0] acc;
    logic signed [63:0] wv, num;
    vertex_res_t r;
    logic sat;
    sat = 1'b0;
    v[0] = $signed(vx); v[1] = $signed(vy); v[2] = $signed(vz); v[3] = $signed(vw);
    for (int j = 0; j < 4; j++) begin
      acc = '0;
      for (int k = 0; k < 4; k++)
        acc += 96'(v[k]) * 96'($signed(mat_shadow[k*4+j]));
      p[j] = sat32(64'(acc >>> FracBits), sat);
    end
    r.wz = (p[3] == 0);
    if (!r.wz) begin
      wv = p[3];
      for (int j = 0; j < 4; j++) begin
        num = p[j] * 64'sd65536;
        p[j] = sat32(num / wv, sat);
      end
    end
    r.x = p[0][31:0]; r.y = p[1][31:0]; r.z = p[2][31:0]; r.w = p[3][31:0];
    r.sat = sat;
    return r;
  endfunction

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // timeout
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // receiver stall: random bursts, one long hold-off
  initial begin
    int n;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (200) @(negedge clk_i);
        long_hold = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    vertex_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result x=%h", $time, out_x_o);
        errors++;
      end else begin
        e = pending_res.pop_front();
        if ({out_x_o, out_y_o, out_z_o, out_w_o, w_was_zero_o, saturated_o} !==
            {e.x, e.y, e.z, e.w, e.wz, e.sat}) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h w=%h wz=%b sat=%b",
                   $time, e.x, e.y, e.z, e.w, e.wz, e.sat);
          $display("%0t:          actual x=%h y=%h z=%h w=%h wz=%b sat=%b",
                   $time, out_x_o, out_y_o, out_z_o, out_w_o, w_was_zero_o,
                   saturated_o);
          errors++;
        end
      end
    end
  end

  // drive one request and wait for acceptance; expectation logged on accept
  task automatic send_request(input stim_row_t s);
    vertex_res_t r;
    req_type_i <= s.kind;
    coef_index_i <= s.idx;
    coef_value_i <= s.coef;
    in_x_i <= s.vx; in_y_i <= s.vy; in_z_i <= s.vz; in_w_i <= s.vw;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (s.kind == ReqLoad) begin
      mat_shadow[s.idx] = s.coef;
    end else begin
      r = transform_vertex(s.vx, s.vy, s.vz, s.vw);
      if (s.typed && r != s.res) begin
        $display("%0t: table row disagrees with predictor, expected %h actual %h",
                 $time, s.res, r);
        errors++;
      end
      pending_res = {pending_res, r};
    end
    @(negedge clk_i);
    // random sender gap
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
  endtask

  function automatic stim_row_t vtx(input logic [31:0] x, y, z, w);
    stim_row_t s;
    s = '{kind: ReqTransform, idx: 4'($urandom), coef: $urandom, vx: x, vy: y, vz: z,
          vw: w, typed: 1'b0, res: '{default: '0}};
    return s;
  endfunction

  function automatic stim_row_t vtx_t(input logic [31:0] x, y, z, w,
                                      input vertex_res_t r);
    stim_row_t s;
    s = vtx(x, y, z, w);
    s.typed = 1'b1;
    s.res = r;
    return s;
  endfunction

  function automatic stim_row_t load(input logic [3:0] i, input logic [31:0] c);
    stim_row_t s;
    s = '{kind: ReqLoad, idx: i, coef: c, vx: $urandom, vy: $urandom, vz: $urandom,
          vw: $urandom, typed: 1'b0, res: '{default: '0}};
    return s;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
    endcase
  endfunction

  stim_row_t dir_table [$];

  initial begin
    stim_row_t s;
    bit hold_done;
    bit drain_done;
    for (int i = 0; i < 16; i++) mat_shadow[i] = (i % 5 == 0) ? One : 32'h0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    dir_table = '{
      // identity, w = 1: passes through
      vtx_t(32'h0002_0000, 32'hfffe_0000, 32'h0000_8000, One,
            '{32'h0002_0000, 32'hfffe_0000, 32'h0000_8000, One, 1'b0, 1'b0}),
      // w zero: unchanged, flagged
      vtx_t(32'h0003_0000, 32'h0, 32'h7fff_ffff, 32'h0,
            '{32'h0003_0000, 32'h0, 32'h7fff_ffff, 32'h0, 1'b0 | 1'b1, 1'b0}),
      // w tiny: x overflows on the divide
      vtx_t(32'h0001_0000, 32'h0, 32'h0, 32'h0000_0001,
            '{32'h7fff_ffff, 32'h0, 32'h0, One, 1'b0, 1'b1}),
      // divide by w = 2
      vtx_t(32'h0004_0000, 32'hfffc_0000, 32'h0001_0000, 32'h0002_0000,
            '{32'h0002_0000, 32'hfffe_0000, 32'h0000_8000, One, 1'b0, 1'b0}),
      vtx(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff),
      vtx(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000),
      load(4'd3, 32'h0),  load(4'd15, 32'h0),
      // full-size coefficients overflow the product
      load(4'd0, 32'h7fff_ffff), load(4'd1, 32'h8000_0000),
      vtx(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0),
      load(4'd15, 32'hffff_ffff),
      vtx(32'h0, 32'h0, 32'h0, 32'hffff_0000),
      load(4'd12, 32'h0002_0000), load(4'd7, 32'hffff_8000),
      vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
      vtx(32'h0001_0000, 32'hffff_ffff, 32'h1234_5678, 32'h0000_0010),
      load(4'd0, One), load(4'd1, 32'h0), load(4'd3, 32'h0), load(4'd7, 32'h0),
      load(4'd12, 32'h0), load(4'd15, One),
      vtx_t(32'h0, 32'h0, 32'h0, 32'hffff_0000,
            '{32'h0, 32'h0, 32'h0, One, 1'b0, 1'b0})
    };
    foreach (dir_table[i]) send_request(dir_table[i]);

    // random part: full matrix reloads, single loads and vertices, mixed at random
    for (int n = 0; n < 750; ) begin
      if (!hold_done && n >= 160) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && n >= 300) begin
        drain_done = 1'b1;
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (pending_res.size() != 0) @(negedge clk_i);
      end
      if (n > 650) calm = 1'b1;
      if ($urandom_range(0, 39) == 0) begin
        for (int i = 0; i < 16; i++) begin
          s = load(i[3:0], $urandom_range(0, 3) == 0 ? 32'h0 : rand_word());
          send_request(s);
        end
        n += 16;
      end else if ($urandom_range(0, 9) == 0) begin
        send_request(load(4'($urandom), rand_word()));
        n++;
      end else begin
        send_request(vtx(rand_word(), rand_word(), rand_word(), rand_word()));
        n++;
      end
    end
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
